FILE: hdl/pbd_pkg.sv
// shared types, codes and keyword tables for the detokenizer
`timescale 1ns / 1ps

package pbd_pkg;

	localparam logic [1:0] KIND_CHAR = 2'd0;
	localparam logic [1:0] KIND_KEY  = 2'd1;
	localparam logic [1:0] KIND_LINE = 2'd2;
	localparam logic [1:0] KIND_EOL  = 2'd3;

	localparam logic [7:0] BYTE_CR     = 8'h0d;
	localparam logic [7:0] BYTE_QUOTE  = 8'h22;
	localparam logic [7:0] BYTE_COLON  = 8'h3a;
	localparam logic [7:0] BYTE_PREFIX = 8'h80;

	localparam logic [2:0] HDR_LEN    = 3'd4;
	localparam logic [2:0] HDR_LINE_LO = 3'd2;
	localparam logic [2:0] HDR_LINE_HI = 3'd3;

	localparam logic [1:0] MT_FIRST  = 2'd0;
	localparam logic [1:0] MT_SECOND = 2'd1;
	localparam logic [1:0] MT_THIRD  = 2'd2;

	typedef struct packed {
		logic        hit;
		logic [1:0]  kind;
		logic [15:0] value;
	} pbd_res_t;

	function automatic logic second_known(input logic [7:0] b);
		second_known = (b == 8'h80) || (b == 8'h81) ||
			(b >= 8'h84 && b <= 8'h92) || (b >= 8'h94 && b <= 8'hac) ||
			(b == 8'hb3) || (b == 8'hb6) || (b == 8'hb7);
	endfunction

	function automatic logic single_keyword(input logic [7:0] b);
		single_keyword = (b == 8'h2a) || (b == 8'h2b) || (b == 8'h2d) ||
			(b == 8'h2f) || (b == 8'h5e) || (b >= 8'h83 && b <= 8'h8b) ||
			(b >= 8'h9e && b <= 8'hab) || (b == 8'haf) || (b == 8'hb1) ||
			(b == 8'hb2) || (b >= 8'hc0 && b <= 8'hcb);
	endfunction

endpackage

FILE: hdl/pbd_charmap.sv
// literal byte to unicode codepoint mapping per machine type
`timescale 1ns / 1ps

module pbd_charmap (
	input  logic [7:0]  data,
	input  logic [1:0]  machine_type,
	output logic [15:0] codepoint
);
	import pbd_pkg::*;

	logic [7:0] lower;
	logic       lower_hit;
	logic       alt;

	always_comb begin
		lower_hit = 1'b1;
		case (data)
			8'ha1: lower = 8'h61;
			8'h9a: lower = 8'h62;
			8'h9f: lower = 8'h63;
			8'h9c: lower = 8'h64;
			8'h92: lower = 8'h65;
			8'haa: lower = 8'h66;
			8'h97: lower = 8'h67;
			8'h98: lower = 8'h68;
			8'ha6: lower = 8'h69;
			8'haf: lower = 8'h6a;
			8'ha9: lower = 8'h6b;
			8'hb8: lower = 8'h6c;
			8'hb3: lower = 8'h6d;
			8'hb0: lower = 8'h6e;
			8'hb7: lower = 8'h6f;
			8'h9e: lower = 8'h70;
			8'ha0: lower = 8'h71;
			8'h9d: lower = 8'h72;
			8'ha4: lower = 8'h73;
			8'h96: lower = 8'h74;
			8'ha5: lower = 8'h75;
			8'hab: lower = 8'h76;
			8'ha3: lower = 8'h77;
			8'h9b: lower = 8'h78;
			8'hbd: lower = 8'h79;
			8'ha2: lower = 8'h7a;
			default: begin
				lower     = 8'h00;
				lower_hit = 1'b0;
			end
		endcase
	end

	always_comb begin
		alt = 1'b0;
		if (machine_type == MT_SECOND || machine_type == MT_THIRD) begin
			alt = (data == 8'h80) || (data == 8'h8b) || (data == 8'h90) ||
				(data == 8'h93) || (data == 8'h94) || (data == 8'hbe);
		end
		if (machine_type == MT_THIRD && (data == 8'h6c || data == 8'h7f)) begin
			alt = 1'b1;
		end
	end

	always_comb begin
		if (data >= 8'h20 && data <= 8'h5d) begin
			codepoint = {8'h00, data};
		end else if (lower_hit) begin
			codepoint = {8'h00, lower};
		end else if (alt) begin
			codepoint = {8'hf0, data};
		end else begin
			codepoint = {8'he0, data};
		end
	end

endmodule

FILE: hdl/pbd_step.sv
// per-byte decode logic and line/mode state registers
`timescale 1ns / 1ps

module pbd_step (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [7:0]      data,
	input  logic            eof,
	input  logic [1:0]      machine_type,
	output pbd_pkg::pbd_res_t res
);
	import pbd_pkg::*;

	logic       in_string_q, in_remark_q, prefix_q;
	logic [2:0] hdr_cnt_q;
	logic [7:0] line_lo_q;

	logic       in_string_d, in_remark_d, prefix_d;
	logic [2:0] hdr_cnt_d;
	logic [7:0] line_lo_d;
	logic [15:0] cp;

	pbd_charmap u_charmap (
		.data         (data),
		.machine_type (machine_type),
		.codepoint    (cp)
	);

	always_comb begin
		in_string_d = in_string_q;
		in_remark_d = in_remark_q;
		prefix_d    = prefix_q;
		hdr_cnt_d   = hdr_cnt_q;
		line_lo_d   = line_lo_q;
		res.hit     = 1'b0;
		res.kind    = KIND_CHAR;
		res.value   = 16'h0000;
		if (prefix_q) begin
			prefix_d = 1'b0;
			if (second_known(data)) begin
				res.hit   = 1'b1;
				res.kind  = KIND_KEY;
				res.value = {BYTE_PREFIX, data};
				if (data == BYTE_PREFIX) begin
					in_remark_d = 1'b1;
				end
			end
		end else if (data == BYTE_CR && hdr_cnt_q == HDR_LEN) begin
			hdr_cnt_d   = 3'd0;
			in_string_d = 1'b0;
			in_remark_d = 1'b0;
			res.hit     = 1'b1;
			res.kind    = KIND_EOL;
		end else if (in_string_q) begin
			res.hit   = 1'b1;
			res.value = cp;
			if (data == BYTE_QUOTE) begin
				in_string_d = 1'b0;
			end
		end else if (in_remark_q) begin
			res.hit   = 1'b1;
			res.value = cp;
			if (data == BYTE_COLON) begin
				in_remark_d = 1'b0;
			end
		end else if (hdr_cnt_q < HDR_LEN) begin
			if (hdr_cnt_q == HDR_LINE_LO) begin
				line_lo_d = data;
			end
			hdr_cnt_d = hdr_cnt_q + 3'd1;
			if (hdr_cnt_q == HDR_LINE_HI) begin
				res.hit   = 1'b1;
				res.kind  = KIND_LINE;
				res.value = {data, line_lo_q};
			end
		end else if (data == BYTE_PREFIX) begin
			prefix_d = 1'b1;
		end else if (data == BYTE_QUOTE) begin
			in_string_d = 1'b1;
			res.hit     = 1'b1;
			res.value   = {8'h00, BYTE_QUOTE};
		end else if (single_keyword(data)) begin
			res.hit   = 1'b1;
			res.kind  = KIND_KEY;
			res.value = {8'h00, data};
		end else begin
			res.hit   = 1'b1;
			res.value = cp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_string_q <= 1'b0;
			in_remark_q <= 1'b0;
			prefix_q    <= 1'b0;
			hdr_cnt_q   <= 3'd0;
			line_lo_q   <= 8'h00;
		end else if (en) begin
			if (eof) begin
				in_string_q <= 1'b0;
				in_remark_q <= 1'b0;
				prefix_q    <= 1'b0;
				hdr_cnt_q   <= 3'd0;
				line_lo_q   <= 8'h00;
			end else begin
				in_string_q <= in_string_d;
				in_remark_q <= in_remark_d;
				prefix_q    <= prefix_d;
				hdr_cnt_q   <= hdr_cnt_d;
				line_lo_q   <= line_lo_d;
			end
		end
	end

endmodule

FILE: hdl/prefixed_basic_detokenizer_core.sv
// top level: input register, decode step and result register
//
// Accepts one program byte per cycle while results are taken and gives at
// most one result per byte. A byte is held in the input register, is decoded
// against the line and mode state, and its result is loaded into the output
// register when that register is empty or its result is being taken.
// Throughput is one byte per clock as long as results are taken; the input
// register lets a new byte in while a finished result waits at the output.
// Bytes that give no result (header bytes before the line number, the
// keyword prefix, unknown second keyword bytes) still pass through the input register and decode step.
// machine_type resets to 1 and is written by cfg_we/cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps

module prefixed_basic_detokenizer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] value
);
	import pbd_pkg::*;

	logic [1:0] machine_type_q;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eof_s1;
	logic       advance;
	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [15:0] value_q;
	pbd_res_t   res;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			machine_type_q <= MT_SECOND;
		end else if (cfg_we) begin
			machine_type_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			eof_s1  <= end_of_file;
		end
	end

	pbd_step u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (advance),
		.data         (data_s1),
		.eof          (eof_s1),
		.machine_type (machine_type_q),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.hit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q  <= res.kind;
			value_q <= res.value;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;

endmodule

FILE: hdl/pbd_checker.sv
// port-level checks for the detokenizer, bound to the top level
`timescale 1ns / 1ps

module pbd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_ready,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  kind,
	input  logic [15:0] value
);
	import pbd_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value))
		else $error("result changed while stalled");

	// input only stalls behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	a_eol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_EOL |-> value == 16'h0000)
		else $error("end of line with nonzero value");

	a_key_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_KEY |-> value[14:8] == 7'd0)
		else $error("malformed keyword id");

	a_char_page: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_CHAR |->
			value[15:8] == 8'h00 || value[15:8] == 8'he0 || value[15:8] == 8'hf0)
		else $error("codepoint outside expected pages");

endmodule

bind prefixed_basic_detokenizer_core pbd_checker u_pbd_checker (.*);

FILE: verif/prefixed_basic_detokenizer_core_test.sv
// self-checking testbench for the tokenized basic detokenizer core
`timescale 1ns / 1ps

module prefixed_basic_detokenizer_core_test;
	import pbd_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_BYTES = 250;
	localparam int PHASES = 8;

	typedef struct packed {
		logic [7:0] b;
		logic       eof;
	} prog_byte_t;

	typedef struct packed {
		logic        hit;
		logic [1:0]  kind;
		logic [15:0] value;
	} token_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_wdata = MT_SECOND;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_file = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [15:0] value;

	prefixed_basic_detokenizer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.end_of_file(end_of_file),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.value(value)
	);

	prog_byte_t prog_q[$];
	token_t     tok_q[$];

	// predictor state
	logic [1:0] mach = MT_SECOND;
	logic       str_mode = 1'b0;
	logic       rem_mode = 1'b0;
	logic       pfx_wait = 1'b0;
	logic [2:0] hdr_cnt = 3'd0;
	logic [7:0] line_lo = 8'h00;

	logic [7:0] opening_bytes [0:24] = '{
		8'h0d, 8'hff, 8'h34, 8'h12, 8'h2a, 8'h80, 8'hb7, 8'h80, 8'h82, 8'h80,
		8'h0d, 8'h22, 8'ha1, 8'h22, 8'h80, 8'h80, 8'h41, 8'h3a, 8'hff, 8'h0d,
		8'h00, 8'h00, 8'hff, 8'hff, 8'h80
	};

	bit         in_xfer, out_xfer;
	bit         tx_idle = 1'b1, rx_idle = 1'b1;
	bit         tx_busy = 1'b0;
	int         tx_gap, rx_gap;
	int         hold_reqs, holds_done, hold_left;
	int         mismatches, results_checked, bytes_sent, bytes_queued, stall_cycles;
	prog_byte_t tx_item;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [7:0] lower_letter(input logic [7:0] c);
		case (c)
			8'ha1: return "a";
			8'h9a: return "b";
			8'h9f: return "c";
			8'h9c: return "d";
			8'h92: return "e";
			8'haa: return "f";
			8'h97: return "g";
			8'h98: return "h";
			8'ha6: return "i";
			8'haf: return "j";
			8'ha9: return "k";
			8'hb8: return "l";
			8'hb3: return "m";
			8'hb0: return "n";
			8'hb7: return "o";
			8'h9e: return "p";
			8'ha0: return "q";
			8'h9d: return "r";
			8'ha4: return "s";
			8'h96: return "t";
			8'ha5: return "u";
			8'hab: return "v";
			8'ha3: return "w";
			8'h9b: return "x";
			8'hbd: return "y";
			8'ha2: return "z";
			default: return 8'h00;
		endcase
	endfunction

	function automatic logic [15:0] glyph(input logic [7:0] c);
		logic [7:0] letter;
		logic       alt;
		letter = lower_letter(c);
		alt = 1'b0;
		if (c >= 8'h20 && c <= 8'h5d)
			return {8'h00, c};
		if (letter != 8'h00)
			return {8'h00, letter};
		if (mach == MT_SECOND || mach == MT_THIRD) begin
			case (c)
				8'h80, 8'h8b, 8'h90, 8'h93, 8'h94, 8'hbe: alt = 1'b1;
				default: alt = 1'b0;
			endcase
		end
		if (mach == MT_THIRD && (c == 8'h6c || c == 8'h7f))
			alt = 1'b1;
		return {alt ? 8'hf0 : 8'he0, c};
	endfunction

	function automatic bit ext_keyword(input logic [7:0] b);
		return (b >= 8'h80 && b <= 8'hac && b != 8'h82 && b != 8'h83 && b != 8'h93) ||
			b == 8'hb3 || b == 8'hb6 || b == 8'hb7;
	endfunction

	function automatic bit base_keyword(input logic [7:0] b);
		case (b)
			8'h2a, 8'h2b, 8'h2d, 8'h2f, 8'h5e, 8'haf, 8'hb1, 8'hb2: return 1'b1;
			default: return (b >= 8'h83 && b <= 8'h8b) || (b >= 8'h9e && b <= 8'hab) ||
				(b >= 8'hc0 && b <= 8'hcb);
		endcase
	endfunction

	function automatic token_t detok_step(input logic [7:0] b, input logic eof);
		token_t t;
		t = '0;
		if (pfx_wait) begin
			pfx_wait = 1'b0;
			if (ext_keyword(b)) begin
				t = '{1'b1, KIND_KEY, {BYTE_PREFIX, b}};
				if (b == BYTE_PREFIX)
					rem_mode = 1'b1;
			end
		end else if (b == BYTE_CR && hdr_cnt == HDR_LEN) begin
			hdr_cnt = 3'd0;
			str_mode = 1'b0;
			rem_mode = 1'b0;
			t = '{1'b1, KIND_EOL, 16'h0000};
		end else if (str_mode) begin
			t = '{1'b1, KIND_CHAR, glyph(b)};
			if (b == BYTE_QUOTE)
				str_mode = 1'b0;
		end else if (rem_mode) begin
			t = '{1'b1, KIND_CHAR, glyph(b)};
			if (b == BYTE_COLON)
				rem_mode = 1'b0;
		end else if (hdr_cnt != HDR_LEN) begin
			if (hdr_cnt == HDR_LINE_LO)
				line_lo = b;
			if (hdr_cnt == HDR_LINE_HI)
				t = '{1'b1, KIND_LINE, {b, line_lo}};
			hdr_cnt = hdr_cnt + 3'd1;
		end else if (b == BYTE_PREFIX) begin
			pfx_wait = 1'b1;
		end else if (b == BYTE_QUOTE) begin
			str_mode = 1'b1;
			t = '{1'b1, KIND_CHAR, {8'h00, BYTE_QUOTE}};
		end else if (base_keyword(b)) begin
			t = '{1'b1, KIND_KEY, {8'h00, b}};
		end else begin
			t = '{1'b1, KIND_CHAR, glyph(b)};
		end
		if (eof) begin
			str_mode = 1'b0;
			rem_mode = 1'b0;
			pfx_wait = 1'b0;
			hdr_cnt = 3'd0;
			line_lo = 8'h00;
		end
		return t;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic eof);
		prog_q.push_back({b, eof});
		bytes_queued++;
	endtask

	// any byte except carriage return
	function automatic logic [7:0] body_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		return (b == BYTE_CR) ? 8'h0c : b;
	endfunction

	task automatic settle();
		while (prog_q.size() != 0 || tx_busy || tok_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// byte sender
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_xfer)
				tx_busy = 1'b0;
			if (!tx_busy) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (prog_q.size() > 0) begin
					tx_item = prog_q.pop_front();
					data_byte <= tx_item.b;
					end_of_file <= tx_item.eof;
					tx_busy = 1'b1;
					tx_gap = tx_idle ? $urandom_range(0, 4) : 0;
				end
			end
			in_valid <= tx_busy;
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_xfer)
				rx_gap = rx_idle ? $urandom_range(0, 4) : 0;
			if (hold_left == 0 && holds_done < hold_reqs) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// prediction, checking and watchdog
	always @(posedge clk) begin
		token_t predicted;
		in_xfer = arst_n && in_valid && in_ready;
		out_xfer = arst_n && out_valid && out_ready;
		if (cfg_we)
			mach = cfg_wdata;
		if (in_xfer) begin
			bytes_sent++;
			predicted = detok_step(data_byte, end_of_file);
			if (predicted.hit)
				tok_q.push_back(predicted);
		end
		if (out_xfer) begin
			if (tok_q.size() == 0) begin
				$error("unexpected transfer: kind %0d value 0x%04h", kind, value);
				mismatches++;
			end else begin
				predicted = tok_q.pop_front();
				results_checked++;
				if (kind !== predicted.kind) begin
					$error("kind: expected %0d, got %0d", predicted.kind, kind);
					mismatches++;
				end
				if (value !== predicted.value) begin
					$error("value: expected 0x%04h, got 0x%04h", predicted.value, value);
					mismatches++;
				end
			end
		end
		if (in_xfer || out_xfer || cfg_we)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int phase, start, n, k, j;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (k = 0; k < 25; k++)
			push_byte(opening_bytes[k], k == 24);

		for (phase = 0; phase < PHASES; phase++) begin
			settle();
			@(negedge clk);
			cfg_we <= 1'b1;
			case (phase)
				0: cfg_wdata <= MT_FIRST;
				1: cfg_wdata <= 2'd3;
				2: cfg_wdata <= MT_THIRD;
				3: cfg_wdata <= MT_SECOND;
				default: cfg_wdata <= 2'($urandom_range(0, 3));
			endcase
			@(negedge clk);
			cfg_we <= 1'b0;
			tx_idle = (phase % 4 == 0) || (phase % 4 == 3);
			rx_idle = (phase % 4 == 0) || (phase % 4 == 2);
			if (phase % 4 == 2)
				hold_reqs++;
			start = bytes_queued;
			while (bytes_queued - start < PHASE_BYTES) begin
				if ($urandom_range(0, 9) == 0) begin
					n = $urandom_range(1, 8);
					for (k = 0; k < n; k++)
						push_byte(8'($urandom()), $urandom_range(0, 7) == 0);
				end else begin
					for (k = 0; k < 4; k++)
						push_byte(($urandom_range(0, 7) == 0) ? BYTE_CR :
							8'($urandom_range(0, 255)), 1'b0);
					n = $urandom_range(0, 10);
					for (k = 0; k < n; k++) begin
						case ($urandom_range(0, 7))
							0, 1: push_byte(body_byte(), 1'b0);
							2: begin
								push_byte(BYTE_PREFIX, 1'b0);
								case ($urandom_range(0, 7))
									0: push_byte(8'($urandom_range(0, 255)), 1'b0);
									1: push_byte(BYTE_CR, 1'b0);
									default: push_byte(8'($urandom_range(8'h80, 8'hb8)), 1'b0);
								endcase
							end
							3: begin
								push_byte(BYTE_QUOTE, 1'b0);
								for (j = $urandom_range(0, 5); j > 0; j--)
									push_byte(body_byte(), 1'b0);
								if ($urandom_range(0, 3) != 0)
									push_byte(BYTE_QUOTE, 1'b0);
							end
							4: begin
								push_byte(BYTE_PREFIX, 1'b0);
								push_byte(BYTE_PREFIX, 1'b0);
								for (j = $urandom_range(0, 5); j > 0; j--)
									push_byte(body_byte(), 1'b0);
								if ($urandom_range(0, 1) != 0)
									push_byte(BYTE_COLON, 1'b0);
							end
							5: push_byte(8'($urandom_range(8'h83, 8'hcb)), 1'b0);
							default: push_byte(8'($urandom_range(8'h20, 8'h7f)), 1'b0);
						endcase
					end
					case ($urandom_range(0, 15))
						0: push_byte(BYTE_PREFIX, 1'b1);
						1: push_byte(body_byte(), 1'b1);
						2: push_byte(BYTE_CR, 1'b1);
						default: push_byte(BYTE_CR, 1'b0);
					endcase
				end
			end
		end
		settle();

		$display("checked %0d results from %0d program bytes over machine types 0 to 3,",
			results_checked, bytes_sent);
		$display("with idle gaps on both sides, long output stalls and end-of-file resets");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
